// ===== rtl/hex8_shape_function_eval_unit_macros.svh =====
// Assertion macros used by the hex8 shape function RTL.
`ifndef HEX8_SHAPE_FUNCTION_EVAL_UNIT_MACROS_SVH
`define HEX8_SHAPE_FUNCTION_EVAL_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HEX8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HEX8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hex8sf_pkg.sv =====
package hex8sf_pkg;

  // Q2.14 fixed point: 16384 is 1.0
  localparam int COORD_W = 16;
  localparam int FACT_W  = 16;   // 1 +/- c, 0..32768
  localparam int PAIR_W  = 31;   // product of two factors, up to 2^30
  localparam int TRIP_W  = 46;   // product of three factors, up to 2^45
  localparam int GMAG_W  = 14;   // derivative magnitude, 0..8192
  localparam int OUT_W   = 15;
  localparam int NODE_W  = 3;

  localparam logic signed [COORD_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [COORD_W-1:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic [NODE_W-1:0]         LAST_NODE   = 3'd7;

  // Corner sign per node: bit0 xi, bit1 eta, bit2 zeta; set means +1
  localparam logic [2:0] CORNER_SIGN [8] = '{
    3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
  };

endpackage

// ===== rtl/hex8_shape_function_eval_unit.sv =====
// Each node result passes the node sequencer, the stage 1 and 2 registers and the output register.
// Throughput: one result per cycle unless a stalled output holds the pipeline; items are paced
// by the node sequencer that issues the eight nodes of a coordinate triple one per cycle.
// The next item is taken in the cycle the sequencer issues node 7 of the current one.
// Reset (rst_n low, synchronous) clears all valid bits; no state survives between items.
module hex8_shape_function_eval_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hex8sf_pkg::COORD_W-1:0] in_coord_xi,
  input  logic signed [hex8sf_pkg::COORD_W-1:0] in_coord_eta,
  input  logic signed [hex8sf_pkg::COORD_W-1:0] in_coord_zeta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hex8sf_pkg::NODE_W-1:0]       out_node_index,
  output logic [hex8sf_pkg::OUT_W-1:0]        out_shape_value,
  output logic signed [hex8sf_pkg::OUT_W-1:0] out_grad_xi,
  output logic signed [hex8sf_pkg::OUT_W-1:0] out_grad_eta,
  output logic signed [hex8sf_pkg::OUT_W-1:0] out_grad_zeta,
  output logic                                out_last_node
);

  `include "hex8_shape_function_eval_unit_macros.svh"

  localparam int FW = hex8sf_pkg::FACT_W;
  localparam int PW = hex8sf_pkg::PAIR_W;
  localparam int TW = hex8sf_pkg::TRIP_W;
  localparam int GW = hex8sf_pkg::GMAG_W;
  localparam int OW = hex8sf_pkg::OUT_W;
  localparam int NW = hex8sf_pkg::NODE_W;

  // whole pipeline advances unless a result waits on a stalled output
  logic en;
  assign en = !(out_valid && out_stall);

  // ---------------- stage 0: clamp, factors, node sequencer ----------------
  logic                 seq_vld_r;
  logic [NW-1:0]        seq_cnt_r;
  logic [FW-1:0]        fm_r [3];
  logic [FW-1:0]        fp_r [3];
  logic                 in_acc;
  logic                 seq_issue;
  logic signed [hex8sf_pkg::COORD_W-1:0] cin [3];
  logic signed [hex8sf_pkg::COORD_W-1:0] ccl [3];
  logic [FW-1:0]        fm_nxt [3];
  logic [FW-1:0]        fp_nxt [3];

  assign seq_issue = seq_vld_r && en;
  assign in_stall  = seq_vld_r && !(en && seq_cnt_r == hex8sf_pkg::LAST_NODE);
  assign in_acc    = in_valid && !in_stall;

  assign cin[0] = in_coord_xi;
  assign cin[1] = in_coord_eta;
  assign cin[2] = in_coord_zeta;

  // clamp to +/-1.0, then form 1 - c and 1 + c
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (cin[d] > hex8sf_pkg::ONE_Q14) begin
        ccl[d] = hex8sf_pkg::ONE_Q14;
      end else if (cin[d] < hex8sf_pkg::NEG_ONE_Q14) begin
        ccl[d] = hex8sf_pkg::NEG_ONE_Q14;
      end else begin
        ccl[d] = cin[d];
      end
      fm_nxt[d] = FW'(17'(hex8sf_pkg::ONE_Q14) - 17'(ccl[d]));
      fp_nxt[d] = FW'(17'(hex8sf_pkg::ONE_Q14) + 17'(ccl[d]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_vld_r <= 1'b0;
      seq_cnt_r <= '0;
    end else if (in_acc) begin
      seq_vld_r <= 1'b1;
      seq_cnt_r <= '0;
    end else if (seq_issue) begin
      seq_cnt_r <= seq_cnt_r + 1'b1;
      if (seq_cnt_r == hex8sf_pkg::LAST_NODE) begin
        seq_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fm_r <= fm_nxt;
      fp_r <= fp_nxt;
    end
  end

  // ---------------- stage 1: factor select, pair products ----------------
  logic          s1_vld_r;
  logic [NW-1:0] s1_node_r;
  logic [2:0]    s1_sgn_r;
  logic [FW-1:0] s1_fz_r;
  logic [PW-1:0] s1_pyz_r, s1_pxz_r, s1_pxy_r;
  logic [2:0]    sel_sgn;
  logic [FW-1:0] fx, fy, fz;
  logic [2*FW-1:0] pyz_full, pxz_full, pxy_full;

  always_comb begin
    sel_sgn  = hex8sf_pkg::CORNER_SIGN[seq_cnt_r];
    fx       = sel_sgn[0] ? fp_r[0] : fm_r[0];
    fy       = sel_sgn[1] ? fp_r[1] : fm_r[1];
    fz       = sel_sgn[2] ? fp_r[2] : fm_r[2];
    pyz_full = fy * fz;
    pxz_full = fx * fz;
    pxy_full = fx * fy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= seq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_node_r <= seq_cnt_r;
      s1_sgn_r  <= sel_sgn;
      s1_fz_r   <= fz;
      s1_pyz_r  <= pyz_full[PW-1:0];
      s1_pxz_r  <= pxz_full[PW-1:0];
      s1_pxy_r  <= pxy_full[PW-1:0];
    end
  end

  // ---------------- stage 2: triple product, derivative rounding ----------------
  logic          s2_vld_r;
  logic [NW-1:0] s2_node_r;
  logic [2:0]    s2_sgn_r;
  logic [TW-1:0] s2_trip_r;
  logic [GW-1:0] s2_gx_r, s2_gy_r, s2_gz_r;
  logic [TW:0]   trip_full;
  logic [PW:0]   gx_sum, gy_sum, gz_sum;

  // divide by 8 of a Q4.28 pair: (p + 2^16) >> 17
  always_comb begin
    trip_full = (TW+1)'(s1_pxy_r) * (TW+1)'(s1_fz_r);
    gx_sum    = {1'b0, s1_pyz_r} + (PW+1)'(1 << 16);
    gy_sum    = {1'b0, s1_pxz_r} + (PW+1)'(1 << 16);
    gz_sum    = {1'b0, s1_pxy_r} + (PW+1)'(1 << 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_node_r <= s1_node_r;
      s2_sgn_r  <= s1_sgn_r;
      s2_trip_r <= trip_full[TW-1:0];
      s2_gx_r   <= gx_sum[GW+16:17];
      s2_gy_r   <= gy_sum[GW+16:17];
      s2_gz_r   <= gz_sum[GW+16:17];
    end
  end

  // ---------------- stage 3: value rounding, signs, output register ----------------
  logic          out_valid_r;
  logic [NW-1:0] out_node_r;
  logic [OW-1:0] out_val_r;
  logic [OW-1:0] out_gx_r, out_gy_r, out_gz_r;
  logic          out_last_r;
  logic [TW:0]   val_sum;
  logic [OW-1:0] gx_nxt, gy_nxt, gz_nxt;

  // (P + 2^30) >> 31 divides the Q6.42 product by 8 and rounds half up
  always_comb begin
    val_sum = {1'b0, s2_trip_r} + (TW+1)'(1 << 30);
    gx_nxt  = s2_sgn_r[0] ? {1'b0, s2_gx_r} : OW'(-{1'b0, s2_gx_r});
    gy_nxt  = s2_sgn_r[1] ? {1'b0, s2_gy_r} : OW'(-{1'b0, s2_gy_r});
    gz_nxt  = s2_sgn_r[2] ? {1'b0, s2_gz_r} : OW'(-{1'b0, s2_gz_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_node_r <= s2_node_r;
      out_val_r  <= val_sum[OW+30:31];
      out_gx_r   <= gx_nxt;
      out_gy_r   <= gy_nxt;
      out_gz_r   <= gz_nxt;
      out_last_r <= (s2_node_r == hex8sf_pkg::LAST_NODE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_node_r;
  assign out_shape_value = out_val_r;
  assign out_grad_xi     = out_gx_r;
  assign out_grad_eta    = out_gy_r;
  assign out_grad_zeta   = out_gz_r;
  assign out_last_node   = out_last_r;

  // ---------------- assertions ----------------
  // nodes of one item leave back to back in order
  `HEX8_ASSERT(a_node_seq, (out_valid && !out_stall && !out_last_node) |=> (out_valid && out_node_index == $past(out_node_index) + 3'd1), "node sequence broken")
  // sequencer mid-item must hold off new items
  `HEX8_ASSERT(a_busy_stall, (seq_vld_r && seq_cnt_r != hex8sf_pkg::LAST_NODE) |-> in_stall, "item accepted while sequencer busy")
  // an accepted item starts at node 0
  `HEX8_ASSERT(a_start_node0, (in_valid && !in_stall) |=> (seq_vld_r && seq_cnt_r == 3'd0), "sequencer did not restart")
  // shape value never exceeds 1.0
  `HEX8_ASSERT(a_val_range, out_valid |-> (out_shape_value <= 15'd16384), "shape value out of range")
  // xi and zeta derivatives stay within +/-0.5
  `HEX8_ASSERT(a_grad_range, out_valid |-> ((out_grad_xi <= 15'sd8192) && (out_grad_xi >= -15'sd8192) && (out_grad_zeta <= 15'sd8192) && (out_grad_zeta >= -15'sd8192)), "derivative out of range")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = hex8sf_pkg::COORD_W;
  localparam int NW = hex8sf_pkg::NODE_W;
  localparam int OW = hex8sf_pkg::OUT_W;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RAND_ITEMS   = 250;
  localparam int CALM_ITEMS   = 40;
  localparam int PRESS_ITEMS  = 12;
  localparam int PRESS_CYCLES = 90;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_ROWS     = 15;

  // corner sign per node, 3 bits each (bit0 xi, bit1 eta, bit2 zeta), node 0 in the low bits
  localparam bit [23:0] HEX_CORNERS =
    {3'b110, 3'b111, 3'b101, 3'b100, 3'b010, 3'b011, 3'b001, 3'b000};

  typedef struct packed {
    logic [NW-1:0]         node;
    logic [OW-1:0]         shape;
    logic signed [OW-1:0]  gx;
    logic signed [OW-1:0]  gy;
    logic signed [OW-1:0]  gz;
    logic                  last;
  } node_result_t;

  // directed row; when typed is set, node 0 of the item is taken from the row
  typedef struct packed {
    logic signed [CW-1:0]  xi;
    logic signed [CW-1:0]  eta;
    logic signed [CW-1:0]  zeta;
    bit                    typed;
    logic [OW-1:0]         shape;
    logic signed [OW-1:0]  gx;
    logic signed [OW-1:0]  gy;
    logic signed [OW-1:0]  gz;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_coord_xi;
  logic signed [CW-1:0] in_coord_eta;
  logic signed [CW-1:0] in_coord_zeta;
  logic out_valid;
  logic out_stall;
  logic [NW-1:0]         out_node_index;
  logic [OW-1:0]         out_shape_value;
  logic signed [OW-1:0]  out_grad_xi;
  logic signed [OW-1:0]  out_grad_eta;
  logic signed [OW-1:0]  out_grad_zeta;
  logic                  out_last_node;

  // typed node 0 values riding along with the offered item
  bit                    drv_typed;
  logic [OW-1:0]         drv_shape;
  logic signed [OW-1:0]  drv_gx;
  logic signed [OW-1:0]  drv_gy;
  logic signed [OW-1:0]  drv_gz;

  node_result_t node_expect_q[$];
  node_result_t exp_r;
  node_result_t pred_nodes[8];
  stim_row_t    dir_rows[DIR_ROWS];

  int  err_cnt;
  int  items_taken;
  int  nodes_checked;
  int  clamped_items;
  int  cycle_cnt;
  bit  calm;
  bit  press_req;
  bit  press_done;
  int  press_cnt;
  int  stall_left;

  hex8_shape_function_eval_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coord_xi    (in_coord_xi),
    .in_coord_eta   (in_coord_eta),
    .in_coord_zeta  (in_coord_zeta),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node_index (out_node_index),
    .out_shape_value(out_shape_value),
    .out_grad_xi    (out_grad_xi),
    .out_grad_eta   (out_grad_eta),
    .out_grad_zeta  (out_grad_zeta),
    .out_last_node  (out_last_node)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp to +/-1.0 in Q2.14
  function automatic int clamp_q14(input logic signed [CW-1:0] raw);
    int v;
    v = raw;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  // trilinear shape values and gradients of all eight nodes at one point
  function automatic void shape_grads_at(input logic signed [CW-1:0] xi,
                                         input logic signed [CW-1:0] eta,
                                         input logic signed [CW-1:0] zeta,
                                         output node_result_t res[8]);
    int        c[3];
    bit [63:0] fm[3];
    bit [63:0] fp[3];
    bit [63:0] fx, fy, fz, val, mx, my, mz;
    bit [2:0]  s;
    c[0] = clamp_q14(xi);
    c[1] = clamp_q14(eta);
    c[2] = clamp_q14(zeta);
    for (int d = 0; d < 3; d++) begin
      fm[d] = 64'(16384 - c[d]);
      fp[d] = 64'(16384 + c[d]);
    end
    for (int n = 0; n < 8; n++) begin
      s  = HEX_CORNERS[n*3 +: 3];
      fx = s[0] ? fp[0] : fm[0];
      fy = s[1] ? fp[1] : fm[1];
      fz = s[2] ? fp[2] : fm[2];
      // divide by 8 and round half up
      val = (fx * fy * fz + (64'd1 << 30)) >> 31;
      mx  = (fy * fz + (64'd1 << 16)) >> 17;
      my  = (fx * fz + (64'd1 << 16)) >> 17;
      mz  = (fx * fy + (64'd1 << 16)) >> 17;
      res[n].node  = NW'(n);
      res[n].shape = OW'(val);
      // a zero magnitude stays zero after negation
      res[n].gx    = s[0] ? OW'(mx) : OW'(-mx);
      res[n].gy    = s[1] ? OW'(my) : OW'(-my);
      res[n].gz    = s[2] ? OW'(mz) : OW'(-mz);
      res[n].last  = (n == 7);
    end
  endfunction

  // mostly in range, some full 16-bit patterns, some bounds and just-beyond values
  function automatic logic signed [CW-1:0] pick_coord();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      v = $urandom_range(0, 32768) - 16384;
    end else if (sel == 6) begin
      v = $urandom_range(0, 65535);
    end else if (sel == 7) begin
      case ($urandom_range(0, 6))
        0: v = -16384;
        1: v = 16384;
        2: v = 0;
        3: v = -32768;
        4: v = 32767;
        5: v = 16385;
        default: v = -16385;
      endcase
    end else begin
      // near a face of the element
      v = $urandom_range(0, 1) ? 16384 - $urandom_range(0, 64) : $urandom_range(0, 64) - 16384;
    end
    return CW'(v);
  endfunction

  // offer one item and hold it until it is taken
  task automatic offer_item(input logic signed [CW-1:0] xi,
                            input logic signed [CW-1:0] eta,
                            input logic signed [CW-1:0] zeta,
                            input stim_row_t row);
    if (!calm && !(press_req && !press_done) && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_coord_xi   = xi;
    in_coord_eta  = eta;
    in_coord_zeta = zeta;
    drv_typed     = row.typed;
    drv_shape     = row.shape;
    drv_gx        = row.gx;
    drv_gy        = row.gy;
    drv_gz        = row.gz;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: one long hold-off on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (press_req && !press_done) begin
      out_stall <= 1'b1;
      press_cnt++;
      if (press_cnt >= PRESS_CYCLES) press_done = 1'b1;
    end else if (stall_left > 0 && !calm) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare accepted results, then predict for the accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (node_expect_q.size() == 0) begin
          $error("node result with nothing expected: node %0d", out_node_index);
          err_cnt++;
        end else begin
          exp_r = node_expect_q.pop_front();
          nodes_checked++;
          if (out_node_index !== exp_r.node) begin
            $error("node_index: expected %0d, got %0d", exp_r.node, out_node_index);
            err_cnt++;
          end
          if (out_shape_value !== exp_r.shape) begin
            $error("shape_value: expected %0d, got %0d", exp_r.shape, out_shape_value);
            err_cnt++;
          end
          if (out_grad_xi !== exp_r.gx) begin
            $error("grad_xi: expected %0d, got %0d", exp_r.gx, out_grad_xi);
            err_cnt++;
          end
          if (out_grad_eta !== exp_r.gy) begin
            $error("grad_eta: expected %0d, got %0d", exp_r.gy, out_grad_eta);
            err_cnt++;
          end
          if (out_grad_zeta !== exp_r.gz) begin
            $error("grad_zeta: expected %0d, got %0d", exp_r.gz, out_grad_zeta);
            err_cnt++;
          end
          if (out_last_node !== exp_r.last) begin
            $error("last_node: expected %0d, got %0d", exp_r.last, out_last_node);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        shape_grads_at(in_coord_xi, in_coord_eta, in_coord_zeta, pred_nodes);
        if (drv_typed) begin
          pred_nodes[0].shape = drv_shape;
          pred_nodes[0].gx    = drv_gx;
          pred_nodes[0].gy    = drv_gy;
          pred_nodes[0].gz    = drv_gz;
        end
        for (int n = 0; n < 8; n++) node_expect_q.push_back(pred_nodes[n]);
        items_taken++;
        if (clamp_q14(in_coord_xi) != in_coord_xi || clamp_q14(in_coord_eta) != in_coord_eta
            || clamp_q14(in_coord_zeta) != in_coord_zeta)
          clamped_items++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d node results outstanding",
               cycle_cnt, node_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_coord_xi   = '0;
    in_coord_eta  = '0;
    in_coord_zeta = '0;
    out_stall     = 1'b0;
    drv_typed     = 1'b0;
    drv_shape     = '0;
    drv_gx        = '0;
    drv_gy        = '0;
    drv_gz        = '0;
    calm          = 1'b0;
    press_req     = 1'b0;
    press_done    = 1'b0;
    press_cnt     = 0;
    stall_left    = 0;
    err_cnt       = 0;
    items_taken   = 0;
    nodes_checked = 0;
    clamped_items = 0;
    cycle_cnt     = 0;

    // node 0 is typed where it reads straight off the corner factors
    dir_rows = '{
      // center: every factor 1.0
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 15'd2048, -15'sd2048, -15'sd2048, -15'sd2048},
      // corner of node 0
      '{-16'sd16384, -16'sd16384, -16'sd16384, 1'b1,
        15'd16384, -15'sd8192, -15'sd8192, -15'sd8192},
      // opposite corner: node 0 gets zero magnitudes with negative sign
      '{16'sd16384, 16'sd16384, 16'sd16384, 1'b1, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      // most negative codes clamp to the node 0 corner
      '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
        15'd16384, -15'sd8192, -15'sd8192, -15'sd8192},
      // most positive codes clamp to the far corner
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      // one coordinate at the far face each
      '{16'sd16384, -16'sd16384, -16'sd16384, 1'b1, 15'd0, -15'sd8192, 15'sd0, 15'sd0},
      '{-16'sd16384, 16'sd16384, -16'sd16384, 1'b1, 15'd0, 15'sd0, -15'sd8192, 15'sd0},
      '{-16'sd16384, -16'sd16384, 16'sd16384, 1'b1, 15'd0, 15'sd0, 15'sd0, -15'sd8192},
      // just beyond the bounds, then interior and on-bound points
      '{16'sd16385, -16'sd16385, 16'sd0, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      '{16'sd8192, -16'sd8192, 16'sd4096, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      '{16'sd16384, 16'sd0, -16'sd16384, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      '{-16'sd1, 16'sd1, 16'sd0, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      // alternating bit patterns, both clamp
      '{16'sh5555, 16'shAAAA, 16'sh7FFF, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      '{16'shAAAA, 16'sh5555, 16'sh8001, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0},
      '{16'sd3, -16'sd5, 16'sd16383, 1'b0, 15'd0, 15'sd0, 15'sd0, 15'sd0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++)
      offer_item(dir_rows[i].xi, dir_rows[i].eta, dir_rows[i].zeta, dir_rows[i]);

    // long receiver hold-off while items keep coming
    press_req = 1'b1;
    for (int i = 0; i < PRESS_ITEMS; i++)
      offer_item(pick_coord(), pick_coord(), pick_coord(), '0);

    // random items, the tail without idling
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      offer_item(pick_coord(), pick_coord(), pick_coord(), '0);
    end
    in_valid = 1'b0;

    while (node_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d coordinate triples taken (%0d needing clamping), %0d node results checked",
             items_taken, clamped_items, nodes_checked);
    $display("covered corners, faces, center, out-of-range codes and random interior points");
    if (err_cnt == 0 && node_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
